// ----- rtl/pwm_pkg.sv -----
// pwm_pkg: shared constants, register indexes and the control word of the
// perspective warp mapper pipeline. No dependencies.
`default_nettype none

package pwm_pkg;

   // coefficient registers
   localparam int REG_BITS  = 48;
   localparam int NUM_REGS  = 8;
   localparam int IDX_BITS  = 3;
   localparam int ADDR_BITS = 6;
   localparam int DATA_BITS = 64;

   // register indexes
   localparam logic [IDX_BITS-1:0] IDX_M00 = 3'd0;
   localparam logic [IDX_BITS-1:0] IDX_M01 = 3'd1;
   localparam logic [IDX_BITS-1:0] IDX_M02 = 3'd2;
   localparam logic [IDX_BITS-1:0] IDX_M10 = 3'd3;
   localparam logic [IDX_BITS-1:0] IDX_M11 = 3'd4;
   localparam logic [IDX_BITS-1:0] IDX_M12 = 3'd5;
   localparam logic [IDX_BITS-1:0] IDX_M20 = 3'd6;
   localparam logic [IDX_BITS-1:0] IDX_M21 = 3'd7;

   // quotient and result
   localparam int QUO_BITS = 15;
   localparam int OUT_BITS = 16;
   localparam int NUM_CELLS = QUO_BITS + 1;
   localparam logic signed [OUT_BITS-1:0] OUT_MAX = 16'sh7fff;
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = 16'sh8000;

   // control word handed from cell to cell
   typedef struct packed {
      logic valid;
      logic bad;
      logic neg_u;
      logic neg_v;
      logic sat_u;
      logic sat_v;
   } ctl_type;

endpackage

`default_nettype wire

// ----- rtl/pwm_mac.sv -----
// pwm_mac: one matrix row, a*x + b*y + c, in two registered stages.
// Depends on pwm_pkg.
`default_nettype none

module pwm_mac #(
   parameter int COORD_BITS = 12,
   parameter int SUM_W      = 63
) (
   input  wire                                 clock,
   input  wire                                 adv,
   input  wire signed [pwm_pkg::REG_BITS-1:0] coef_a,
   input  wire signed [pwm_pkg::REG_BITS-1:0] coef_b,
   input  wire signed [SUM_W-1:0]             addend,
   input  wire        [COORD_BITS-1:0]        x,
   input  wire        [COORD_BITS-1:0]        y,
   output logic signed [SUM_W-1:0]            sum
);

   localparam int PROD_W = pwm_pkg::REG_BITS + COORD_BITS + 1;

   logic signed [PROD_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [SUM_W-1:0]  c_ff, sum_ff, sum_in;

   // products of coefficient and coordinate
   assign pa_in = PROD_W'(coef_a) * PROD_W'($signed({1'b0, x}));
   assign pb_in = PROD_W'(coef_b) * PROD_W'($signed({1'b0, y}));

   // row sum
   assign sum_in = SUM_W'(pa_ff) + SUM_W'(pb_ff) + c_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         c_ff   <= addend;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

// ----- rtl/pwm_div_cell.sv -----
// pwm_div_cell: one quotient bit of the u/w and v/w restoring division;
// the top cell only checks for saturation. Depends on pwm_pkg.
`default_nettype none

module pwm_div_cell #(
   parameter int SUM_W = 63,
   parameter int BIT   = 15
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               adv,
   input  wire  pwm_pkg::ctl_type            ctl_i,
   input  wire  [SUM_W-1:0]                  den_i,
   input  wire  [SUM_W-1:0]                  rem_u_i,
   input  wire  [SUM_W-1:0]                  rem_v_i,
   input  wire  [pwm_pkg::QUO_BITS-1:0]      q_u_i,
   input  wire  [pwm_pkg::QUO_BITS-1:0]      q_v_i,
   output pwm_pkg::ctl_type                  ctl_o,
   output logic [SUM_W-1:0]                  den_o,
   output logic [SUM_W-1:0]                  rem_u_o,
   output logic [SUM_W-1:0]                  rem_v_o,
   output logic [pwm_pkg::QUO_BITS-1:0]      q_u_o,
   output logic [pwm_pkg::QUO_BITS-1:0]      q_v_o
);

   localparam int DW = SUM_W + pwm_pkg::QUO_BITS;

   logic [DW-1:0]    dsh;
   logic             ge_u, ge_v;
   pwm_pkg::ctl_type ctl_ff, ctl_in;
   logic [SUM_W-1:0] den_ff, rem_u_ff, rem_u_in, rem_v_ff, rem_v_in;
   logic [pwm_pkg::QUO_BITS-1:0] q_u_ff, q_u_in, q_v_ff, q_v_in;

   // trial divisor shifted to this bit
   assign dsh  = DW'(den_i) << BIT;
   assign ge_u = DW'(rem_u_i) >= dsh;
   assign ge_v = DW'(rem_v_i) >= dsh;

   generate
      if (BIT == pwm_pkg::QUO_BITS) begin : g_sat
         // saturation check, nothing subtracted
         always_comb begin
            ctl_in       = ctl_i;
            ctl_in.sat_u = ge_u;
            ctl_in.sat_v = ge_v;
            rem_u_in     = rem_u_i;
            rem_v_in     = rem_v_i;
            q_u_in       = q_u_i;
            q_v_in       = q_v_i;
         end
      end else begin : g_bit
         // restoring step
         always_comb begin
            ctl_in   = ctl_i;
            rem_u_in = rem_u_i;
            rem_v_in = rem_v_i;
            q_u_in   = q_u_i;
            q_v_in   = q_v_i;
            if (!ctl_i.sat_u && ge_u) begin
               rem_u_in  = rem_u_i - dsh[SUM_W-1:0];
               q_u_in[BIT] = 1'b1;
            end
            if (!ctl_i.sat_v && ge_v) begin
               rem_v_in  = rem_v_i - dsh[SUM_W-1:0];
               q_v_in[BIT] = 1'b1;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff   <= den_i;
         rem_u_ff <= rem_u_in;
         rem_v_ff <= rem_v_in;
         q_u_ff   <= q_u_in;
         q_v_ff   <= q_v_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign den_o   = den_ff;
   assign rem_u_o = rem_u_ff;
   assign rem_v_o = rem_v_ff;
   assign q_u_o   = q_u_ff;
   assign q_v_o   = q_v_ff;

endmodule

`default_nettype wire

// ----- rtl/perspective_warp_mapper_unit.sv -----
// perspective_warp_mapper_unit: top level, coefficient registers, matrix rows,
// divider cell chain and result register. Depends on pwm_pkg, pwm_mac, pwm_div_cell.
//
//   channel   ports                        word
//   req       req_valid/req_stall          dest_x, dest_y
//   rsp       rsp_valid/rsp_stall          src_x, src_y, bad_weight
//   csr       psel/penable/pwrite/paddr    eight 48-bit coefficients at 8*i
//
// one word per clock; the whole pipeline holds while a result waits under
// rsp_stall. stages: input register, two row stages, sign stage, sixteen
// divider cells (top one a saturation check, rest one quotient bit each),
// result register. reset clears all valid bits and loads the identity matrix.
`default_nettype none

module perspective_warp_mapper_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [COORD_BITS-1:0]                req_dest_x,
   input  wire  [COORD_BITS-1:0]                req_dest_y,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [pwm_pkg::OUT_BITS-1:0]  rsp_src_x,
   output logic signed [pwm_pkg::OUT_BITS-1:0]  rsp_src_y,
   output logic                                 rsp_bad_weight,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [pwm_pkg::ADDR_BITS-1:0]        paddr,
   input  wire  [pwm_pkg::DATA_BITS-1:0]        pwdata,
   output logic [pwm_pkg::DATA_BITS-1:0]        prdata,
   output logic                                 pready
);

   localparam int SUM_W = pwm_pkg::REG_BITS + COORD_BITS + 3;
   localparam int NC    = pwm_pkg::NUM_CELLS;
   localparam logic [pwm_pkg::REG_BITS-1:0] ONE_REG =
      pwm_pkg::REG_BITS'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;

   logic signed [pwm_pkg::REG_BITS-1:0] coef_ff [pwm_pkg::NUM_REGS];
   logic                                adv, accept, wr;
   logic [pwm_pkg::IDX_BITS-1:0]        widx;
   logic [COORD_BITS-1:0]               x_ff, y_ff;
   logic                                v0_ff, v1_ff, v2_ff;
   logic signed [SUM_W-1:0]             u_sum, v_sum, w_sum, u_add;
   pwm_pkg::ctl_type                    prep_in;
   logic [SUM_W-1:0]                    mag_u_in, mag_v_in;
   pwm_pkg::ctl_type                    ctl0_ff;
   logic [SUM_W-1:0]                    den0_ff, rem_u0_ff, rem_v0_ff;

   pwm_pkg::ctl_type                    ctl_c   [NC+1];
   logic [SUM_W-1:0]                    den_c   [NC+1];
   logic [SUM_W-1:0]                    rem_u_c [NC+1];
   logic [SUM_W-1:0]                    rem_v_c [NC+1];
   logic [pwm_pkg::QUO_BITS-1:0]        q_u_c   [NC+1];
   logic [pwm_pkg::QUO_BITS-1:0]        q_v_c   [NC+1];

   logic                                rsp_valid_ff;
   logic signed [pwm_pkg::OUT_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic                                bad_ff;

   // handshake: the pipeline moves unless a result is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = reset || !adv;
   assign accept    = req_valid && !req_stall;

   // coefficient registers
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;
   assign widx   = paddr[pwm_pkg::ADDR_BITS-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwm_pkg::NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[pwm_pkg::IDX_M00] <= ONE_REG;
         coef_ff[pwm_pkg::IDX_M11] <= ONE_REG;
      end else if (wr) begin
         coef_ff[widx] <= pwdata[pwm_pkg::REG_BITS-1:0];
      end
   end

   assign prdata = psel ? pwm_pkg::DATA_BITS'(coef_ff[widx]) : '0;

   // input register and row-stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_dest_x;
         y_ff <= req_dest_y;
      end
   end

   // matrix rows
   assign u_add = SUM_W'(coef_ff[pwm_pkg::IDX_M02]);

   pwm_mac #(.COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_row_u (
      .clock(clock), .adv(adv),
      .coef_a(coef_ff[pwm_pkg::IDX_M00]), .coef_b(coef_ff[pwm_pkg::IDX_M01]),
      .addend(u_add), .x(x_ff), .y(y_ff), .sum(u_sum)
   );

   pwm_mac #(.COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_row_v (
      .clock(clock), .adv(adv),
      .coef_a(coef_ff[pwm_pkg::IDX_M10]), .coef_b(coef_ff[pwm_pkg::IDX_M11]),
      .addend(SUM_W'(coef_ff[pwm_pkg::IDX_M12])), .x(x_ff), .y(y_ff), .sum(v_sum)
   );

   pwm_mac #(.COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_row_w (
      .clock(clock), .adv(adv),
      .coef_a(coef_ff[pwm_pkg::IDX_M20]), .coef_b(coef_ff[pwm_pkg::IDX_M21]),
      .addend(ONE_SUM), .x(x_ff), .y(y_ff), .sum(w_sum)
   );

   // sign and magnitude, weight check
   always_comb begin
      prep_in.valid = v2_ff;
      prep_in.bad   = w_sum[SUM_W-1] || (w_sum == '0);
      prep_in.neg_u = u_sum[SUM_W-1];
      prep_in.neg_v = v_sum[SUM_W-1];
      prep_in.sat_u = 1'b0;
      prep_in.sat_v = 1'b0;
      mag_u_in = u_sum[SUM_W-1] ? SUM_W'(-u_sum) : SUM_W'(u_sum);
      mag_v_in = v_sum[SUM_W-1] ? SUM_W'(-v_sum) : SUM_W'(v_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (adv) begin
         ctl0_ff <= prep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den0_ff   <= w_sum;
         rem_u0_ff <= mag_u_in;
         rem_v0_ff <= mag_v_in;
      end
   end

   // head of the chain
   assign ctl_c[0]   = ctl0_ff;
   assign den_c[0]   = den0_ff;
   assign rem_u_c[0] = rem_u0_ff;
   assign rem_v_c[0] = rem_v0_ff;
   assign q_u_c[0]   = '0;
   assign q_v_c[0]   = '0;

   // divider cell chain, most significant bit first
   generate
      for (genvar gi = 0; gi < NC; gi++) begin : g_cell
         pwm_div_cell #(.SUM_W(SUM_W), .BIT(pwm_pkg::QUO_BITS - gi)) u_cell (
            .clock(clock), .reset(reset), .adv(adv),
            .ctl_i(ctl_c[gi]), .den_i(den_c[gi]),
            .rem_u_i(rem_u_c[gi]), .rem_v_i(rem_v_c[gi]),
            .q_u_i(q_u_c[gi]), .q_v_i(q_v_c[gi]),
            .ctl_o(ctl_c[gi+1]), .den_o(den_c[gi+1]),
            .rem_u_o(rem_u_c[gi+1]), .rem_v_o(rem_v_c[gi+1]),
            .q_u_o(q_u_c[gi+1]), .q_v_o(q_v_c[gi+1])
         );
      end
   endgenerate

   // sign, saturation and the invalid-weight result
   always_comb begin
      if (ctl_c[NC].neg_u) begin
         sx_in = ctl_c[NC].sat_u ? pwm_pkg::OUT_MIN : -$signed({1'b0, q_u_c[NC]});
      end else begin
         sx_in = ctl_c[NC].sat_u ? pwm_pkg::OUT_MAX : $signed({1'b0, q_u_c[NC]});
      end
      if (ctl_c[NC].neg_v) begin
         sy_in = ctl_c[NC].sat_v ? pwm_pkg::OUT_MIN : -$signed({1'b0, q_v_c[NC]});
      end else begin
         sy_in = ctl_c[NC].sat_v ? pwm_pkg::OUT_MAX : $signed({1'b0, q_v_c[NC]});
      end
      if (ctl_c[NC].bad) begin
         sx_in = '0;
         sy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_c[NC].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         bad_ff <= ctl_c[NC].bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_src_x      = sx_ff;
   assign rsp_src_y      = sy_ff;
   assign rsp_bad_weight = bad_ff;

   // checks
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bad_ff |-> sx_ff == '0 && sy_ff == '0)
      else $error("bad weight word with nonzero coordinates");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      ctl_c[0].valid && den_c[0] == '0 |-> ctl_c[0].bad)
      else $error("zero weight not flagged");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
